// ===== src/ssd_pkg.sv =====
// shared types, constants and character decode for the seven-segment scan display
`timescale 1ns / 1ps

package ssd_pkg;

    // display geometry: digit positions first, status (icon) position last
    localparam int NUM_POSITIONS = 5;
    localparam int STATUS_POS    = NUM_POSITIONS - 1;
    localparam int POS_W         = 3;
    localparam int SEL_W         = 5;
    localparam int SEG_W         = 7;
    localparam int BYTE_W        = 8;

    // stream payload widths
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 16;

    // apb port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // register indexes
    typedef enum logic [0:0] {
        REG_BLINK_TICKS = 1'b0,
        REG_COLON_MASK  = 1'b1
    } reg_index_t;

    // reset values of the registers
    localparam logic [BYTE_W-1:0] BLINK_TICKS_RST = 8'd250;
    localparam logic [BYTE_W-1:0] COLON_MASK_RST  = 8'h01;

    // command codes
    typedef enum logic [2:0] {
        CMD_TICK        = 3'd0,
        CMD_PUTCHAR     = 3'd1,
        CMD_SET_ICON    = 3'd2,
        CMD_CLR_ICON    = 3'd3,
        CMD_SET_FLASH   = 3'd4,
        CMD_CLR_FLASH   = 3'd5,
        CMD_FLASH_DIGIT = 3'd6,
        CMD_CLEAR_ALL   = 3'd7
    } cmd_t;

    // controller to datapath commands
    typedef struct packed {
        logic exec;      // apply the accepted command to the stores
        logic load_out;  // capture a scan result into the output register
    } ctrl_cmd_t;

    // special characters
    localparam logic [BYTE_W-1:0] ASCII_COLON = 8'h3a;
    localparam logic [BYTE_W-1:0] ASCII_DASH  = 8'h2d;
    localparam logic [BYTE_W-1:0] ASCII_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] ASCII_NINE  = 8'h39;
    localparam logic [BYTE_W-1:0] ASCII_UP_A  = 8'h41;
    localparam logic [BYTE_W-1:0] ASCII_UP_Z  = 8'h5a;
    localparam logic [BYTE_W-1:0] ASCII_LO_A  = 8'h61;
    localparam logic [BYTE_W-1:0] ASCII_LO_Z  = 8'h7a;

    localparam logic [BYTE_W-1:0] PAT_DASH   = 8'h40;
    localparam logic [BYTE_W-1:0] FLASH_FULL = 8'hff;

    // segment patterns
    localparam logic [BYTE_W-1:0] DIGIT_PAT [10] = '{
        8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07, 8'h7f, 8'h6f
    };
    localparam logic [BYTE_W-1:0] UPPER_PAT [26] = '{
        8'h77, 8'h40, 8'h39, 8'h3f, 8'h79, 8'h71, 8'h40, 8'h76, 8'h06, 8'h40,
        8'h40, 8'h38, 8'h40, 8'h37, 8'h3f, 8'h73, 8'h40, 8'h50, 8'h6d, 8'h40,
        8'h3e, 8'h3e, 8'h40, 8'h76, 8'h40, 8'h40
    };
    localparam logic [BYTE_W-1:0] LOWER_PAT [26] = '{
        8'h77, 8'h7c, 8'h58, 8'h5e, 8'h79, 8'h71, 8'h40, 8'h40, 8'h40, 8'h40,
        8'h40, 8'h38, 8'h40, 8'h54, 8'h5c, 8'h73, 8'h67, 8'h50, 8'h40, 8'h40,
        8'h3e, 8'h3e, 8'h40, 8'h40, 8'h40, 8'h40
    };

    // character to {mapped, pattern}; space, control codes and punctuation other than the dash unmapped
    function automatic logic [BYTE_W:0] char_pattern(input logic [BYTE_W-1:0] c);
        logic [BYTE_W-1:0] ofs;
        logic [BYTE_W:0]   res;
        ofs = '0;
        res = '0;
        if (c >= ASCII_ZERO && c <= ASCII_NINE) begin
            ofs = c - ASCII_ZERO;
            res = {1'b1, DIGIT_PAT[ofs[3:0]]};
        end else if (c >= ASCII_LO_A && c <= ASCII_LO_Z) begin
            ofs = c - ASCII_LO_A;
            res = {1'b1, LOWER_PAT[ofs[4:0]]};
        end else if (c >= ASCII_UP_A && c <= ASCII_UP_Z) begin
            ofs = c - ASCII_UP_A;
            res = {1'b1, UPPER_PAT[ofs[4:0]]};
        end else if (c == ASCII_DASH) begin
            res = {1'b1, PAT_DASH};
        end
        return res;
    endfunction

endpackage

// ===== src/seven_segment_scan_display_unit.sv =====
// top level of the seven-segment scan display: stream ports, apb registers
`timescale 1ns / 1ps

// Multiplexed seven-segment display driver, four digits plus one icon position.
// Input stream (s_*): one command per transfer; tick, putchar, icon set/clear,
// flash icon set/clear, flash digit, clear all. Only a tick produces a result.
// Output stream (m_*): per tick, the one-hot common line of the scanned position
// and the active-low segment lines, with flash bits inverted in the blink phase.
// Each command is applied at the edge that accepts it, and a tick's result is
// loaded into the output register at that same edge. A command can be
// accepted every cycle; the single output register sets the rate when stalled.
// When the receiver holds m_tready low, the result waits in the output register
// and s_tready follows m_tready, so a new item enters only as the old one leaves.
// Registers on the apb port: blink_ticks at address 0, colon_mask at address 4;
// writes are meant to happen while the block is idle.
// Synchronous reset clears the segment and flash stores, the scan index, the
// blink divider and phase, empties the output register and restores the
// register reset values (blink_ticks 250, colon_mask 1).

module seven_segment_scan_display_unit
    import ssd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // command[2:0], char_code[10:3], position[13:11], icon_mask[21:14], zero pad
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // digit_select[4:0], segment_drive[11:5], zero pad
    output logic [M_TDATA_W-1:0]  m_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    ctrl_cmd_t         cmd;
    cmd_t              command;
    logic [BYTE_W-1:0] char_code;
    logic [POS_W-1:0]  position;
    logic [BYTE_W-1:0] icon_mask;
    logic [BYTE_W-1:0] blink_ticks_reg;
    logic [BYTE_W-1:0] colon_mask_reg;
    logic [SEL_W-1:0]  digit_select;
    logic [SEG_W-1:0]  segment_drive;
    logic              cfg_wr;
    reg_index_t        cfg_idx;

    // unpack the input transfer
    assign command   = cmd_t'(s_tdata[2:0]);
    assign char_code = s_tdata[10:3];
    assign position  = s_tdata[13:11];
    assign icon_mask = s_tdata[21:14];

    // register access
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_index_t'(paddr[2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blink_ticks_reg <= BLINK_TICKS_RST;
            colon_mask_reg  <= COLON_MASK_RST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_BLINK_TICKS: blink_ticks_reg <= pwdata[BYTE_W-1:0];
                REG_COLON_MASK:  colon_mask_reg  <= pwdata[BYTE_W-1:0];
                default:         blink_ticks_reg <= blink_ticks_reg;
            endcase
        end
    end

    // read back
    always_comb begin
        case (cfg_idx)
            REG_BLINK_TICKS: prdata = {{(APB_DATA_W-BYTE_W){1'b0}}, blink_ticks_reg};
            REG_COLON_MASK:  prdata = {{(APB_DATA_W-BYTE_W){1'b0}}, colon_mask_reg};
            default:         prdata = '0;
        endcase
    end

    ssd_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_is_tick (command == CMD_TICK),
        .s_tready  (s_tready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cmd       (cmd)
    );

    ssd_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .command       (command),
        .char_code     (char_code),
        .position      (position),
        .icon_mask     (icon_mask),
        .blink_ticks   (blink_ticks_reg),
        .colon_mask    (colon_mask_reg),
        .digit_select  (digit_select),
        .segment_drive (segment_drive)
    );

    // pack the result transfer
    assign m_tdata = {{(M_TDATA_W-SEL_W-SEG_W){1'b0}}, segment_drive, digit_select};

endmodule

// ===== src/ssd_ctrl.sv =====
// controller state machine: input acceptance and output register occupancy
`timescale 1ns / 1ps

module ssd_ctrl
    import ssd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    input  logic       s_is_tick,
    output logic       s_tready,
    output logic       m_tvalid,
    input  logic       m_tready,
    output ctrl_cmd_t  cmd
);

    typedef enum logic [1:0] {
        ST_EMPTY = 2'b01,
        ST_FULL  = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    // a new item may enter whenever the output slot is free or drains this cycle
    assign s_tready = (state_reg == ST_EMPTY) || m_tready;
    assign m_tvalid = (state_reg == ST_FULL);
    assign accept   = s_tvalid && s_tready;

    assign cmd.exec     = accept;
    assign cmd.load_out = accept && s_is_tick;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_EMPTY: begin
                if (cmd.load_out) state_next = ST_FULL;
            end
            ST_FULL: begin
                if (cmd.load_out) state_next = ST_FULL;
                else if (m_tready) state_next = ST_EMPTY;
            end
            default: state_next = ST_EMPTY;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_EMPTY;
        end else begin
            state_reg <= state_next;
        end
    end

    // a scan result load always comes with an accepted command
    a_load_needs_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> cmd.exec)
        else $error("output load without accepted command");

    // a stalled result stays in the output register
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FULL) && !m_tready |=> state_reg == ST_FULL)
        else $error("stalled result dropped");

    // every loaded result is presented on the next cycle
    a_load_presents: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |=> m_tvalid)
        else $error("loaded result not presented");

endmodule

// ===== src/ssd_datapath.sv =====
// datapath: segment and flash stores, scan index, blink divider, output register
`timescale 1ns / 1ps

module ssd_datapath
    import ssd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  ctrl_cmd_t         cmd,
    input  cmd_t              command,
    input  logic [BYTE_W-1:0] char_code,
    input  logic [POS_W-1:0]  position,
    input  logic [BYTE_W-1:0] icon_mask,
    input  logic [BYTE_W-1:0] blink_ticks,
    input  logic [BYTE_W-1:0] colon_mask,
    output logic [SEL_W-1:0]  digit_select,
    output logic [SEG_W-1:0]  segment_drive
);

    logic [BYTE_W-1:0] seg_reg   [NUM_POSITIONS];
    logic [BYTE_W-1:0] seg_next  [NUM_POSITIONS];
    logic [BYTE_W-1:0] flash_reg [NUM_POSITIONS];
    logic [BYTE_W-1:0] flash_next[NUM_POSITIONS];
    logic [POS_W-1:0]  scan_reg;
    logic [POS_W-1:0]  scan_next;
    logic [BYTE_W-1:0] blink_count_reg;
    logic [BYTE_W-1:0] blink_count_next;
    logic              blink_phase_reg;
    logic              blink_phase_next;
    logic [SEL_W-1:0]  sel_out_reg;
    logic [SEG_W-1:0]  seg_out_reg;

    logic [POS_W-1:0]  scan_pos;
    logic [BYTE_W-1:0] count_inc;
    logic [BYTE_W-1:0] seg_cur;
    logic [BYTE_W-1:0] flash_cur;
    logic [BYTE_W-1:0] seg_shown;
    logic [SEL_W-1:0]  sel_shown;
    logic [BYTE_W:0]   char_dec;

    // scanned position, folded back to zero if out of range
    assign scan_pos  = ({1'b0, scan_reg} >= (POS_W+1)'(NUM_POSITIONS)) ? '0 : scan_reg;
    assign count_inc = blink_count_reg + 8'd1;
    assign char_dec  = char_pattern(char_code);

    // read the scanned entry
    always_comb begin
        seg_cur   = '0;
        flash_cur = '0;
        for (int i = 0; i < NUM_POSITIONS; i++) begin
            if (scan_pos == POS_W'(i)) begin
                seg_cur   = seg_reg[i];
                flash_cur = flash_reg[i];
            end
        end
    end

    // one-hot common line; positions above the select width drive nothing
    always_comb begin
        for (int i = 0; i < SEL_W; i++) begin
            sel_shown[i] = (scan_pos == POS_W'(i));
        end
    end

    // command execution
    always_comb begin
        seg_next         = seg_reg;
        flash_next       = flash_reg;
        scan_next        = scan_reg;
        blink_count_next = blink_count_reg;
        blink_phase_next = blink_phase_reg;
        seg_shown        = seg_cur;
        if (cmd.exec) begin
            case (command)
                CMD_TICK: begin
                    if (count_inc == blink_ticks) begin
                        blink_count_next = '0;
                        blink_phase_next = !blink_phase_reg;
                    end else begin
                        blink_count_next = count_inc;
                    end
                    if (blink_phase_next) seg_shown = seg_cur ^ flash_cur;
                    scan_next = ({1'b0, scan_pos} >= (POS_W+1)'(STATUS_POS)) ?
                                '0 : scan_pos + 1'b1;
                end
                CMD_PUTCHAR: begin
                    if (char_code == ASCII_COLON) begin
                        seg_next[STATUS_POS] = seg_reg[STATUS_POS] | colon_mask;
                    end else if (char_dec[BYTE_W]) begin
                        for (int i = 0; i < NUM_POSITIONS; i++) begin
                            if (position == POS_W'(i)) seg_next[i] = char_dec[BYTE_W-1:0];
                        end
                    end
                end
                CMD_SET_ICON: begin
                    seg_next[STATUS_POS] = seg_reg[STATUS_POS] | icon_mask;
                end
                CMD_CLR_ICON: begin
                    seg_next[STATUS_POS] = seg_reg[STATUS_POS] & ~icon_mask;
                end
                CMD_SET_FLASH: begin
                    flash_next[STATUS_POS] = flash_reg[STATUS_POS] | icon_mask;
                end
                CMD_CLR_FLASH: begin
                    flash_next[STATUS_POS] = flash_reg[STATUS_POS] & ~icon_mask;
                end
                CMD_FLASH_DIGIT: begin
                    // the status position is not a digit
                    for (int i = 0; i < STATUS_POS; i++) begin
                        if (position == POS_W'(i)) flash_next[i] = FLASH_FULL;
                    end
                end
                CMD_CLEAR_ALL: begin
                    for (int i = 0; i < NUM_POSITIONS; i++) begin
                        seg_next[i]   = '0;
                        flash_next[i] = '0;
                    end
                end
                default: begin
                    seg_next = seg_reg;
                end
            endcase
        end
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_POSITIONS; i++) begin
                seg_reg[i]   <= '0;
                flash_reg[i] <= '0;
            end
            scan_reg        <= '0;
            blink_count_reg <= '0;
            blink_phase_reg <= 1'b0;
        end else begin
            seg_reg         <= seg_next;
            flash_reg       <= flash_next;
            scan_reg        <= scan_next;
            blink_count_reg <= blink_count_next;
            blink_phase_reg <= blink_phase_next;
        end
    end

    // output register, loaded on each tick transfer
    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            sel_out_reg <= sel_shown;
            seg_out_reg <= ~seg_shown[SEG_W-1:0];
        end
    end

    assign digit_select  = sel_out_reg;
    assign segment_drive = seg_out_reg;

endmodule

// ===== dv/ssd_scan_checker.sv =====
// scoreboard for the seven-segment scan display: command tracking, scan prediction, compare
`timescale 1ns / 1ps

module ssd_scan_checker
    import ssd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    input  logic                  pready,
    output int                    errors,
    output int                    pending
);

    typedef struct packed {
        logic [SEL_W-1:0] sel;
        logic [SEG_W-1:0] seg;
    } scan_out_t;

    // glyph tables for the character decode
    localparam logic [BYTE_W-1:0] NUMERAL_GLYPH [10] = '{
        8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07, 8'h7f, 8'h6f
    };
    localparam logic [BYTE_W-1:0] CAPITAL_GLYPH [26] = '{
        8'h77, 8'h40, 8'h39, 8'h3f, 8'h79, 8'h71, 8'h40, 8'h76, 8'h06, 8'h40,
        8'h40, 8'h38, 8'h40, 8'h37, 8'h3f, 8'h73, 8'h40, 8'h50, 8'h6d, 8'h40,
        8'h3e, 8'h3e, 8'h40, 8'h76, 8'h40, 8'h40
    };
    localparam logic [BYTE_W-1:0] MINUSCULE_GLYPH [26] = '{
        8'h77, 8'h7c, 8'h58, 8'h5e, 8'h79, 8'h71, 8'h40, 8'h40, 8'h40, 8'h40,
        8'h40, 8'h38, 8'h40, 8'h54, 8'h5c, 8'h73, 8'h67, 8'h50, 8'h40, 8'h40,
        8'h3e, 8'h3e, 8'h40, 8'h40, 8'h40, 8'h40
    };

    // shadow of the display state and registers
    logic [BYTE_W-1:0] seg_store   [NUM_POSITIONS];
    logic [BYTE_W-1:0] flash_store [NUM_POSITIONS];
    logic [POS_W-1:0]  scan_idx;
    logic [BYTE_W-1:0] blink_cnt;
    logic              blink_on;
    logic [BYTE_W-1:0] blink_limit;
    logic [BYTE_W-1:0] colon_bits;

    scan_out_t expected_scans [$];
    scan_out_t want;
    scan_out_t got;

    initial errors = 0;

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        errors++;
    endtask

    // {mapped, pattern} for one character
    function automatic logic [BYTE_W:0] glyph_of(input logic [BYTE_W-1:0] c);
        logic [BYTE_W:0] res;
        res = '0;
        if (c >= ASCII_ZERO && c <= ASCII_NINE)
            res = {1'b1, NUMERAL_GLYPH[4'(c - ASCII_ZERO)]};
        else if (c >= ASCII_LO_A && c <= ASCII_LO_Z)
            res = {1'b1, MINUSCULE_GLYPH[5'(c - ASCII_LO_A)]};
        else if (c >= ASCII_UP_A && c <= ASCII_UP_Z)
            res = {1'b1, CAPITAL_GLYPH[5'(c - ASCII_UP_A)]};
        else if (c == ASCII_DASH)
            res = {1'b1, 8'h40};
        return res;
    endfunction

    // apply one accepted command to the shadow; a tick queues its scan output
    task automatic advance_display(input cmd_t cmd, input logic [BYTE_W-1:0] ch,
                                   input logic [POS_W-1:0] pos,
                                   input logic [BYTE_W-1:0] mask);
        int              s;
        logic [BYTE_W-1:0] pat;
        logic [BYTE_W:0]   g;
        scan_out_t       scan;
        case (cmd)
            CMD_TICK: begin
                s = int'(scan_idx);
                if (s >= NUM_POSITIONS)
                    s = 0;
                blink_cnt = blink_cnt + 8'd1;
                if (blink_cnt == blink_limit) begin
                    blink_cnt = '0;
                    blink_on  = ~blink_on;
                end
                pat = seg_store[POS_W'(s)];
                if (blink_on)
                    pat = pat ^ flash_store[POS_W'(s)];
                scan.sel = SEL_W'(1 << s);
                scan.seg = ~pat[SEG_W-1:0];
                expected_scans.push_back(scan);
                scan_idx = (s >= STATUS_POS) ? '0 : POS_W'(s + 1);
            end
            CMD_PUTCHAR: begin
                // printable only; colon goes to the status byte wherever aimed
                if (ch >= 8'h20 && ch <= 8'h7e) begin
                    if (ch == ASCII_COLON) begin
                        seg_store[STATUS_POS] = seg_store[STATUS_POS] | colon_bits;
                    end else begin
                        g = glyph_of(ch);
                        if (g[BYTE_W] && pos < NUM_POSITIONS)
                            seg_store[pos] = g[BYTE_W-1:0];
                    end
                end
            end
            CMD_SET_ICON:  seg_store[STATUS_POS]   = seg_store[STATUS_POS] | mask;
            CMD_CLR_ICON:  seg_store[STATUS_POS]   = seg_store[STATUS_POS] & ~mask;
            CMD_SET_FLASH: flash_store[STATUS_POS] = flash_store[STATUS_POS] | mask;
            CMD_CLR_FLASH: flash_store[STATUS_POS] = flash_store[STATUS_POS] & ~mask;
            CMD_FLASH_DIGIT: begin
                if (pos < STATUS_POS)
                    flash_store[pos] = 8'hff;
            end
            CMD_CLEAR_ALL: begin
                for (int i = 0; i < NUM_POSITIONS; i++) begin
                    seg_store[i]   = '0;
                    flash_store[i] = '0;
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_POSITIONS; i++) begin
                seg_store[i]   = '0;
                flash_store[i] = '0;
            end
            scan_idx    = '0;
            blink_cnt   = '0;
            blink_on    = 1'b0;
            blink_limit = BLINK_TICKS_RST;
            colon_bits  = COLON_MASK_RST;
            expected_scans.delete();
        end else begin
            // register writes
            if (psel && penable && pwrite && pready) begin
                case (reg_index_t'(paddr[APB_ADDR_W-1:2]))
                    REG_BLINK_TICKS: blink_limit = pwdata[BYTE_W-1:0];
                    REG_COLON_MASK:  colon_bits  = pwdata[BYTE_W-1:0];
                    default: ;
                endcase
            end
            // result transfer against the oldest expectation
            if (m_tvalid && m_tready) begin
                got.sel = m_tdata[SEL_W-1:0];
                got.seg = m_tdata[SEL_W+SEG_W-1:SEL_W];
                if (expected_scans.size() == 0) begin
                    report_mismatch($sformatf("unexpected result sel=%h seg=%h",
                                              got.sel, got.seg));
                end else begin
                    want = expected_scans.pop_front();
                    if (got.sel !== want.sel)
                        report_mismatch($sformatf("digit_select got %h want %h",
                                                  got.sel, want.sel));
                    if (got.seg !== want.seg)
                        report_mismatch($sformatf("segment_drive got %h want %h",
                                                  got.seg, want.seg));
                end
            end
            // command transfer
            if (s_tvalid && s_tready)
                advance_display(cmd_t'(s_tdata[2:0]), s_tdata[10:3], s_tdata[13:11],
                                s_tdata[21:14]);
        end
        pending <= expected_scans.size();
    end

endmodule

// ===== dv/tb_seven_segment_scan_display_unit.sv =====
// testbench top for the seven-segment scan display: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb_seven_segment_scan_display_unit;
    import ssd_pkg::*;

    localparam int  CLK_PERIOD   = 8;
    localparam int  ITEMS_PER_SET = 150;
    localparam real TIMEOUT_NS   = 4.0e6;

    logic                  aclk    = 1'b0;
    logic                  aresetn = 1'b0;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [APB_DATA_W-1:0] pwdata  = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    logic idle_en = 1'b1;
    int   errors;
    int   pending;

    // blink period and colon mask for each random set
    logic [BYTE_W-1:0] blink_sets [4] = '{8'd1, 8'd255, 8'd3, 8'd0};
    logic [BYTE_W-1:0] colon_sets [4] = '{8'hff, 8'h00, 8'h80, 8'h5a};

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    seven_segment_scan_display_unit u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    ssd_scan_checker u_checker (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .pready   (pready),
        .errors   (errors),
        .pending  (pending)
    );

    // receiver back-pressure
    always @(posedge aclk)
        m_tready <= idle_en ? ($urandom_range(99) >= 33) : 1'b1;

    function automatic logic [S_TDATA_W-1:0] pack_command(input cmd_t cmd,
                                                         input logic [BYTE_W-1:0] ch,
                                                         input logic [POS_W-1:0] pos,
                                                         input logic [BYTE_W-1:0] mask);
        return {2'b00, mask, pos, ch, cmd};
    endfunction

    // mostly ticks and characters that map, with some noise in every field
    function automatic logic [S_TDATA_W-1:0] random_command();
        int                r;
        cmd_t              cmd;
        logic [BYTE_W-1:0] ch;
        logic [POS_W-1:0]  pos;
        r = $urandom_range(99);
        if (r < 40)      cmd = CMD_TICK;
        else if (r < 70) cmd = CMD_PUTCHAR;
        else if (r < 76) cmd = CMD_SET_ICON;
        else if (r < 82) cmd = CMD_CLR_ICON;
        else if (r < 87) cmd = CMD_SET_FLASH;
        else if (r < 92) cmd = CMD_CLR_FLASH;
        else if (r < 98) cmd = CMD_FLASH_DIGIT;
        else             cmd = CMD_CLEAR_ALL;
        case ($urandom_range(7))
            0, 1:    ch = ASCII_ZERO + 8'($urandom_range(9));
            2:       ch = ASCII_LO_A + 8'($urandom_range(25));
            3:       ch = ASCII_UP_A + 8'($urandom_range(25));
            4:       ch = ASCII_COLON;
            5:       ch = ASCII_DASH;
            default: ch = 8'($urandom_range(255));
        endcase
        pos = ($urandom_range(9) < 8) ? POS_W'($urandom_range(4)) : POS_W'($urandom_range(7));
        return pack_command(cmd, ch, pos, 8'($urandom_range(255)));
    endfunction

    // one command transfer, with random idle cycles ahead of it
    task automatic send_command(input logic [S_TDATA_W-1:0] data);
        while (idle_en && $urandom_range(99) < 33) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        do @(posedge aclk); while (!s_tready);
    endtask

    // stop sending and let every outstanding scan result come out
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0)
            @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic apb_write(input reg_index_t idx, input logic [BYTE_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'($urandom), value};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // return the bus to idle before the next access
        @(posedge aclk);
    endtask

    initial begin
        #(TIMEOUT_NS);
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset settings, every command, character and position edges
        send_command(pack_command(CMD_TICK,        8'h00,       3'd0, 8'h00));
        send_command(pack_command(CMD_PUTCHAR,     "8",         3'd0, 8'hff));
        send_command(pack_command(CMD_PUTCHAR,     "b",         3'd1, 8'h00));
        send_command(pack_command(CMD_PUTCHAR,     "Z",         3'd2, 8'h00));
        send_command(pack_command(CMD_PUTCHAR,     ASCII_DASH,  3'd3, 8'h00));
        send_command(pack_command(CMD_PUTCHAR,     ASCII_COLON, 3'd7, 8'h00));
        send_command(pack_command(CMD_PUTCHAR,     " ",         3'd0, 8'h00));
        send_command(pack_command(CMD_PUTCHAR,     8'h00,       3'd1, 8'h00));
        send_command(pack_command(CMD_PUTCHAR,     8'hff,       3'd2, 8'hff));
        send_command(pack_command(CMD_PUTCHAR,     "~",         3'd3, 8'h00));
        send_command(pack_command(CMD_PUTCHAR,     "@",         3'd1, 8'h00));
        send_command(pack_command(CMD_PUTCHAR,     "5",         3'd5, 8'h00));
        send_command(pack_command(CMD_SET_ICON,    8'hff,       3'd7, 8'hf0));
        send_command(pack_command(CMD_CLR_ICON,    8'h3a,       3'd2, 8'h30));
        send_command(pack_command(CMD_SET_FLASH,   8'h00,       3'd0, 8'hff));
        send_command(pack_command(CMD_CLR_FLASH,   8'h41,       3'd5, 8'h0f));
        send_command(pack_command(CMD_FLASH_DIGIT, 8'h00,       3'd0, 8'h00));
        send_command(pack_command(CMD_FLASH_DIGIT, 8'h00,       3'd4, 8'h00));
        send_command(pack_command(CMD_FLASH_DIGIT, 8'h00,       3'd7, 8'h00));
        for (int i = 0; i < 5; i++)
            send_command(pack_command(CMD_TICK, 8'h00, 3'd0, 8'h00));
        send_command(pack_command(CMD_PUTCHAR,     "q",         3'd4, 8'h00));
        send_command(pack_command(CMD_CLEAR_ALL,   8'hff,       3'd7, 8'hff));
        send_command(pack_command(CMD_TICK,        8'hff,       3'd7, 8'hff));

        // random sets, each under its own register settings
        for (int set_idx = 0; set_idx < 4; set_idx++) begin
            drain_results();
            apb_write(REG_BLINK_TICKS, blink_sets[set_idx]);
            apb_write(REG_COLON_MASK, colon_sets[set_idx]);
            // one set runs without any idling on either side
            idle_en <= (set_idx != 2);
            for (int n = 0; n < ITEMS_PER_SET; n++) begin
                if (n == ITEMS_PER_SET / 2)
                    drain_results();
                send_command(random_command());
            end
        end
        drain_results();

        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
